FILE: hw/rtl/lwn_pkg.sv
`timescale 1ns / 1ps

package lwn_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CX_W       = 7;
    localparam int CY_W       = 7;
    localparam int CZ_W       = 12;
    localparam int NORM_W     = 21;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int DEF_MAX_WIDTH     = 128;
    localparam int DEF_MAX_HEIGHT    = 128;
    localparam int DEF_MAX_RADIUS_XY = 8;
    localparam int DEF_MAX_RADIUS_Z  = 4;

    localparam int MAX_PLANES = 4095;
    localparam int SQ_W       = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_PLANES   = 3'd2,
        REG_RADIUS_X = 3'd3,
        REG_RADIUS_Y = 3'd4,
        REG_RADIUS_Z = 3'd5
    } cfg_idx_t;

endpackage

FILE: hw/rtl/local_window_l2_norm_3d.sv
`timescale 1ns / 1ps

// Local window L2 norm over a 3-D volume.
//
// Samples enter on the s_ channel in raster order (x fastest, then y, then
// plane), one signed 16-bit value per beat. For every voxel whose box window
// lies wholly inside the volume, one beat leaves on the m_ channel with the
// window centre and the floor square root of the box sum of squares.
// Boundary voxels give no beat.
//
// Registers are written on the cfg_ channel (always ready). They take effect
// at the first voxel of a volume; write them only while the block is idle.
//
// An item that gives no result passes the read, x-sum, y-sum and z-sum
// steps before the next ready. An item that gives a result then also runs
// the bit-serial square root (one root bit per cycle over the 45-bit box
// sum) and loads the output register; no new sample is taken meanwhile.
//
// Reset clears positions, registers (to 128, 128, 64, 2, 2, 1) and the
// output register. When the receiver stalls, the result holds in the output
// register; the next item is still accepted and worked on, but its result
// waits in the output step, with s_tready low, until the register frees up.
module local_window_l2_norm_3d #(
    parameter int MAX_WIDTH     = lwn_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = lwn_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS_XY = lwn_pkg::DEF_MAX_RADIUS_XY,
    parameter int MAX_RADIUS_Z  = lwn_pkg::DEF_MAX_RADIUS_Z
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lwn_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [6:0] centre_x, [13:7] centre_y, [25:14] centre_z, [46:26] local_norm
    output logic [lwn_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lwn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lwn_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lwn_pkg::*;

    localparam int XY_SPAN  = 2 * MAX_RADIUS_XY + 1;
    localparam int Z_SPAN   = 2 * MAX_RADIUS_Z + 1;
    localparam int CELLS    = MAX_WIDTH * MAX_HEIGHT;
    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int YW       = $clog2(MAX_HEIGHT);
    localparam int ZW       = 12;
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int RXW      = $clog2(MAX_RADIUS_XY + 1);
    localparam int RZW      = $clog2(MAX_RADIUS_Z + 1);
    localparam int XMW      = $clog2(XY_SPAN);
    localparam int ZMW      = $clog2(Z_SPAN);
    localparam int SPW      = $clog2(XY_SPAN + 1) + 1;
    localparam int ZSPW     = $clog2(Z_SPAN + 1) + 1;
    localparam int RR_AW    = $clog2(XY_SPAN * MAX_WIDTH);
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int PR_AW    = $clog2(Z_SPAN * CELLS);
    localparam int XS_W     = SQ_W + $clog2(XY_SPAN);
    localparam int CS_W     = XS_W + $clog2(XY_SPAN);
    localparam int DS_W     = CS_W + $clog2(Z_SPAN);
    localparam int ROOT_W   = (DS_W + 1) / 2;
    localparam int RW       = ROOT_W + 2;
    localparam int CNT_W    = $clog2(ROOT_W + 1);
    localparam int PW       = 32;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_XSUM, S_YSUM, S_ZSUM, S_ROOT, S_OUT
    } state_t;

    // configuration registers as written
    logic [7:0]       width_reg, height_reg;
    logic [11:0]      planes_reg;
    logic [3:0]       rx_reg, ry_reg;
    logic [2:0]       rz_reg;

    // values in force for the current volume
    logic [WW-1:0]    act_w_reg;
    logic [HW-1:0]    act_h_reg;
    logic [ZW-1:0]    act_p_reg;
    logic [RXW-1:0]   act_rx_reg, act_ry_reg;
    logic [RZW-1:0]   act_rz_reg;
    logic [WW-1:0]    act_w_next;
    logic [HW-1:0]    act_h_next;
    logic [ZW-1:0]    act_p_next;
    logic [RXW-1:0]   act_rx_next, act_ry_next;
    logic [RZW-1:0]   act_rz_next;

    // position of the next voxel and its ring slots
    logic [XW-1:0]    pos_x_reg;
    logic [YW-1:0]    pos_y_reg;
    logic [ZW-1:0]    pos_z_reg;
    logic [XMW-1:0]   xm_reg, ym_reg;
    logic [ZMW-1:0]   zm_reg;

    // item in flight
    state_t           state_reg;
    logic [XW-1:0]    cx_reg;
    logic [XMW-1:0]   cxm_reg, xold_reg;
    logic [RR_AW-1:0] row_wa_reg, row_ra_reg;
    logic [PR_AW-1:0] pl_wa_reg, pl_ra_reg;
    logic [CELL_AW-1:0] cell_reg;
    logic             xfirst_reg, yfirst_reg, zfirst_reg;
    logic             xsub_reg, ysub_reg, zsub_reg, emit_reg;
    logic [CX_W-1:0]  ocx_reg;
    logic [CY_W-1:0]  ocy_reg;
    logic [CZ_W-1:0]  ocz_reg;
    logic [SAMPLE_W-1:0] mag_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [XS_W-1:0]  xrun_reg, xs_reg;
    logic [CS_W-1:0]  cs_reg;
    logic [2*ROOT_W-1:0] val_reg;
    logic [RW-1:0]    rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // memories and their read registers
    logic [SQ_W-1:0]  xwin_mem [XY_SPAN];
    logic [XS_W-1:0]  row_mem  [XY_SPAN * MAX_WIDTH];
    logic [CS_W-1:0]  col_mem  [MAX_WIDTH];
    logic [CS_W-1:0]  pl_mem   [Z_SPAN * CELLS];
    logic [DS_W-1:0]  dep_mem  [CELLS];
    logic [SQ_W-1:0]  xw_rd_reg;
    logic [XS_W-1:0]  row_rd_reg;
    logic [CS_W-1:0]  col_rd_reg;
    logic [CS_W-1:0]  pl_rd_reg;
    logic [DS_W-1:0]  dep_rd_reg;

    logic             accept, first_vox;
    logic [SPW-1:0]   wx, wy, xo_t, yo_t;
    logic [ZSPW-1:0]  wz, zo_t;
    logic [XMW-1:0]   xold, yold;
    logic [ZMW-1:0]   zold;
    logic [XS_W-1:0]  xs_next;
    logic [CS_W-1:0]  cs_next;
    logic [DS_W-1:0]  ds_next;
    logic [RW-1:0]    rem_sh, trial;
    logic [ROOT_W:0]  root_sat;
    logic [NORM_W-1:0] norm;
    logic [PW-1:0]    nx, ny, nz;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign first_vox = (pos_x_reg == '0) && (pos_y_reg == '0) && (pos_z_reg == '0);

    // clamp the registers at a volume start
    always_comb
    begin
        act_w_next  = act_w_reg;
        act_h_next  = act_h_reg;
        act_p_next  = act_p_reg;
        act_rx_next = act_rx_reg;
        act_ry_next = act_ry_reg;
        act_rz_next = act_rz_reg;
        if (first_vox)
        begin
            if (width_reg == 8'd0)
                act_w_next = WW'(1);
            else if (PW'(width_reg) > PW'(MAX_WIDTH))
                act_w_next = WW'(MAX_WIDTH);
            else
                act_w_next = WW'(width_reg);
            if (height_reg == 8'd0)
                act_h_next = HW'(1);
            else if (PW'(height_reg) > PW'(MAX_HEIGHT))
                act_h_next = HW'(MAX_HEIGHT);
            else
                act_h_next = HW'(height_reg);
            act_p_next  = (planes_reg == 12'd0) ? ZW'(1) : planes_reg;
            act_rx_next = (PW'(rx_reg) > PW'(MAX_RADIUS_XY)) ? RXW'(MAX_RADIUS_XY)
                                                            : RXW'(rx_reg);
            act_ry_next = (PW'(ry_reg) > PW'(MAX_RADIUS_XY)) ? RXW'(MAX_RADIUS_XY)
                                                            : RXW'(ry_reg);
            act_rz_next = (PW'(rz_reg) > PW'(MAX_RADIUS_Z)) ? RZW'(MAX_RADIUS_Z)
                                                           : RZW'(rz_reg);
        end
    end

    // window lengths and the ring slot that leaves the window
    always_comb
    begin
        wx   = SPW'({act_rx_next, 1'b1});
        wy   = SPW'({act_ry_next, 1'b1});
        wz   = ZSPW'({act_rz_next, 1'b1});
        xo_t = SPW'(xm_reg) + SPW'(XY_SPAN) - wx;
        yo_t = SPW'(ym_reg) + SPW'(XY_SPAN) - wy;
        zo_t = ZSPW'(zm_reg) + ZSPW'(Z_SPAN) - wz;
        xold = (xo_t >= SPW'(XY_SPAN)) ? XMW'(xo_t - SPW'(XY_SPAN)) : XMW'(xo_t);
        yold = (yo_t >= SPW'(XY_SPAN)) ? XMW'(yo_t - SPW'(XY_SPAN)) : XMW'(yo_t);
        zold = (zo_t >= ZSPW'(Z_SPAN)) ? ZMW'(zo_t - ZSPW'(Z_SPAN)) : ZMW'(zo_t);
        nx   = PW'(pos_x_reg) + PW'(1);
        ny   = PW'(pos_y_reg) + PW'(1);
        nz   = PW'(pos_z_reg) + PW'(1);
    end

    // running sums: x from the window, y per column, z per cell
    always_comb
    begin
        xs_next = (xfirst_reg ? XS_W'(0) : xrun_reg) + XS_W'(sq_reg)
                - (xsub_reg ? XS_W'(xw_rd_reg) : XS_W'(0));
        cs_next = (yfirst_reg ? CS_W'(0) : col_rd_reg) + CS_W'(xs_reg)
                - (ysub_reg ? CS_W'(row_rd_reg) : CS_W'(0));
        ds_next = (zfirst_reg ? DS_W'(0) : dep_rd_reg) + DS_W'(cs_reg)
                - (zsub_reg ? DS_W'(pl_rd_reg) : DS_W'(0));
    end

    // one root bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg[RW-3:0], val_reg[2*ROOT_W-1 -: 2]};
        trial    = {root_reg, 2'b01};
        root_sat = {1'b0, root_reg};
        norm     = (PW'(root_sat) > PW'((1 << NORM_W) - 1)) ? {NORM_W{1'b1}}
                                                           : NORM_W'(root_reg);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            xw_rd_reg  <= xwin_mem[xold_reg];
            row_rd_reg <= row_mem[row_ra_reg];
            col_rd_reg <= col_mem[cx_reg];
            pl_rd_reg  <= pl_mem[pl_ra_reg];
            dep_rd_reg <= dep_mem[cell_reg];
        end
        if (state_reg == S_XSUM)
            xwin_mem[cxm_reg] <= sq_reg;
        if (state_reg == S_YSUM)
        begin
            col_mem[cx_reg]     <= cs_next;
            row_mem[row_wa_reg] <= xs_reg;
        end
        if (state_reg == S_ZSUM)
        begin
            dep_mem[cell_reg]  <= ds_next;
            pl_mem[pl_wa_reg]  <= cs_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg     <= pos_x_reg;
            cxm_reg    <= xm_reg;
            xold_reg   <= xold;
            row_wa_reg <= RR_AW'(PW'(ym_reg) * PW'(MAX_WIDTH) + PW'(pos_x_reg));
            row_ra_reg <= RR_AW'(PW'(yold) * PW'(MAX_WIDTH) + PW'(pos_x_reg));
            cell_reg   <= CELL_AW'(PW'(pos_y_reg) * PW'(MAX_WIDTH) + PW'(pos_x_reg));
            pl_wa_reg  <= PR_AW'(PW'(zm_reg) * PW'(CELLS)
                        + PW'(pos_y_reg) * PW'(MAX_WIDTH) + PW'(pos_x_reg));
            pl_ra_reg  <= PR_AW'(PW'(zold) * PW'(CELLS)
                        + PW'(pos_y_reg) * PW'(MAX_WIDTH) + PW'(pos_x_reg));
            xfirst_reg <= (pos_x_reg == '0);
            yfirst_reg <= (pos_y_reg == '0);
            zfirst_reg <= (pos_z_reg == '0);
            xsub_reg   <= PW'(pos_x_reg) >= PW'(wx);
            ysub_reg   <= PW'(pos_y_reg) >= PW'(wy);
            zsub_reg   <= PW'(pos_z_reg) >= PW'(wz);
            emit_reg   <= (PW'(pos_x_reg) >= PW'(wx) - PW'(1))
                       && (PW'(pos_y_reg) >= PW'(wy) - PW'(1))
                       && (PW'(pos_z_reg) >= PW'(wz) - PW'(1));
            ocx_reg    <= CX_W'(PW'(pos_x_reg) - PW'(act_rx_next));
            ocy_reg    <= CY_W'(PW'(pos_y_reg) - PW'(act_ry_next));
            ocz_reg    <= CZ_W'(PW'(pos_z_reg) - PW'(act_rz_next));
            mag_reg    <= s_tdata[SAMPLE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
        end
        if (state_reg == S_READ)
            sq_reg <= SQ_W'(PW'(mag_reg) * PW'(mag_reg));
        if (state_reg == S_XSUM)
        begin
            xrun_reg <= xs_next;
            xs_reg   <= xs_next;
        end
        if (state_reg == S_YSUM)
            cs_reg <= cs_next;
        if (state_reg == S_ZSUM)
        begin
            val_reg  <= (2*ROOT_W)'(ds_next);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (state_reg == S_ROOT)
        begin
            val_reg <= {val_reg[2*ROOT_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // control: state, position, registers, output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= 8'd128;
            height_reg    <= 8'd128;
            planes_reg    <= 12'd64;
            rx_reg        <= 4'd2;
            ry_reg        <= 4'd2;
            rz_reg        <= 3'd1;
            act_w_reg     <= WW'(128 > MAX_WIDTH ? MAX_WIDTH : 128);
            act_h_reg     <= HW'(128 > MAX_HEIGHT ? MAX_HEIGHT : 128);
            act_p_reg     <= ZW'(64);
            act_rx_reg    <= RXW'(2 > MAX_RADIUS_XY ? MAX_RADIUS_XY : 2);
            act_ry_reg    <= RXW'(2 > MAX_RADIUS_XY ? MAX_RADIUS_XY : 2);
            act_rz_reg    <= RZW'(1);
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            xm_reg        <= '0;
            ym_reg        <= '0;
            zm_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_WIDTH:    width_reg  <= cfg_data[7:0];
                    REG_HEIGHT:   height_reg <= cfg_data[7:0];
                    REG_PLANES:   planes_reg <= cfg_data[11:0];
                    REG_RADIUS_X: rx_reg     <= cfg_data[3:0];
                    REG_RADIUS_Y: ry_reg     <= cfg_data[3:0];
                    REG_RADIUS_Z: rz_reg     <= cfg_data[2:0];
                    default:      ;
                endcase
            end

            // drop the beat once taken, unless the output step refills it
            if (out_valid_reg && m_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg  <= S_READ;
                        act_w_reg  <= act_w_next;
                        act_h_reg  <= act_h_next;
                        act_p_reg  <= act_p_next;
                        act_rx_reg <= act_rx_next;
                        act_ry_reg <= act_ry_next;
                        act_rz_reg <= act_rz_next;
                        // advance the raster position
                        if (nx >= PW'(act_w_next))
                        begin
                            pos_x_reg <= '0;
                            xm_reg    <= '0;
                            if (ny >= PW'(act_h_next))
                            begin
                                pos_y_reg <= '0;
                                ym_reg    <= '0;
                                if (nz >= PW'(act_p_next))
                                begin
                                    pos_z_reg <= '0;
                                    zm_reg    <= '0;
                                end
                                else
                                begin
                                    pos_z_reg <= ZW'(nz);
                                    zm_reg <= (PW'(zm_reg) == PW'(Z_SPAN - 1)) ? '0
                                                                              : zm_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                pos_y_reg <= YW'(ny);
                                ym_reg <= (PW'(ym_reg) == PW'(XY_SPAN - 1)) ? '0
                                                                           : ym_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pos_x_reg <= XW'(nx);
                            xm_reg <= (PW'(xm_reg) == PW'(XY_SPAN - 1)) ? '0
                                                                       : xm_reg + 1'b1;
                        end
                    end
                end
                S_READ: state_reg <= S_XSUM;
                S_XSUM: state_reg <= S_YSUM;
                S_YSUM: state_reg <= S_ZSUM;
                S_ZSUM:
                begin
                    cnt_reg   <= '0;
                    state_reg <= emit_reg ? S_ROOT : S_IDLE;
                end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (PW'(cnt_reg) == PW'(ROOT_W - 1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= OUT_DATA_W'({norm, ocz_reg, ocy_reg, ocx_reg});
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted beat did not start the read step");

    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> (PW'(cnt_reg) < PW'(ROOT_W)))
        else $error("square root ran past its bit count");

    a_beat_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output step");

    a_no_emit_no_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZSUM && !emit_reg) |=> (state_reg == S_IDLE))
        else $error("boundary voxel entered the square root");

endmodule

FILE: tb/tb_local_window_l2_norm_3d.sv
`timescale 1ns / 1ps

module tb_local_window_l2_norm_3d;
    import lwn_pkg::*;

    localparam int HOLD_START  = 300;   // beats accepted before the long receiver stall
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;    // longer than the result latency
    localparam int STALL_LIMIT = 5000;  // cycles with no beat anywhere
    localparam int ITEM_TARGET = 1800;

    typedef struct packed {
        logic [CX_W-1:0]   cx;
        logic [CY_W-1:0]   cy;
        logic [CZ_W-1:0]   cz;
        logic [NORM_W-1:0] norm;
    } norm_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Queue of samples waiting for the driver, and the norms still owed.
    logic [SAMPLE_W-1:0] sample_q[$];
    norm_beat_t          norm_q[$];

    int  in_beats = 0;
    int  errors = 0;
    int  idle_cnt = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;
    int  planned = 0;

    // Shadow of the block: written registers, latched volume config, sums.
    int unsigned reg_w, reg_h, reg_p, reg_rx, reg_ry, reg_rz;
    int unsigned vol_w, vol_h, vol_p, vol_rx, vol_ry, vol_rz;
    int unsigned at_x, at_y, at_z;
    longint unsigned sq_hist[17];
    longint unsigned row_total;
    longint unsigned row_hist[17*128];
    longint unsigned col_total[128];
    longint unsigned plane_hist[9*16384];
    longint unsigned box_total[16384];

    local_window_l2_norm_3d u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int unsigned clip(int unsigned v, int unsigned hi, bit zero_is_one);
        if (zero_is_one && v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        // Build the root one bit at a time from the top.
        for (int b = 22; b >= 0; b--)
        begin
            probe = root | (64'd1 << b);
            if (probe * probe <= v)
                root = probe;
        end
        return root;
    endfunction

    // Mirror a register write into the shadow copy.
    task automatic shadow_write(input int unsigned idx, input int unsigned val);
        case (idx)
            REG_WIDTH:    reg_w  = val & 8'hFF;
            REG_HEIGHT:   reg_h  = val & 8'hFF;
            REG_PLANES:   reg_p  = val & 12'hFFF;
            REG_RADIUS_X: reg_rx = val & 4'hF;
            REG_RADIUS_Y: reg_ry = val & 4'hF;
            REG_RADIUS_Z: reg_rz = val & 3'h7;
            default: ;
        endcase
    endtask

    // Advance the shadow volume by one voxel and queue the norm it yields.
    task automatic predict_norm(input logic [SAMPLE_W-1:0] smp);
        int unsigned px, py, pz, wx, wy, wz, vox, mag;
        longint unsigned sq, old, root;
        norm_beat_t nb;
        if (at_x == 0 && at_y == 0 && at_z == 0)
        begin
            vol_w  = clip(reg_w, 128, 1);
            vol_h  = clip(reg_h, 128, 1);
            vol_p  = clip(reg_p, MAX_PLANES, 1);
            vol_rx = clip(reg_rx, 8, 0);
            vol_ry = clip(reg_ry, 8, 0);
            vol_rz = clip(reg_rz, 4, 0);
        end
        px = at_x; py = at_y; pz = at_z;
        wx = 2*vol_rx + 1; wy = 2*vol_ry + 1; wz = 2*vol_rz + 1;
        mag = smp[15] ? (32'h10000 - smp) : smp;
        sq = longint'(mag) * mag;

        if (px == 0) row_total = 0;
        if (px >= wx) row_total -= sq_hist[(px - wx) % 17];
        sq_hist[px % 17] = sq;
        row_total += sq;

        if (py == 0) col_total[px] = 0;
        old = (py >= wy) ? row_hist[((py - wy) % 17)*128 + px] : 0;
        col_total[px] = col_total[px] + row_total - old;
        row_hist[(py % 17)*128 + px] = row_total;

        vox = py*128 + px;
        if (pz == 0) box_total[vox] = 0;
        old = (pz >= wz) ? plane_hist[((pz - wz) % 9)*16384 + vox] : 0;
        box_total[vox] = box_total[vox] + col_total[px] - old;
        plane_hist[(pz % 9)*16384 + vox] = col_total[px];

        if (px >= 2*vol_rx && py >= 2*vol_ry && pz >= 2*vol_rz)
        begin
            root = isqrt(box_total[vox]);
            if (root > 2097151) root = 2097151;
            nb.cx = CX_W'(px - vol_rx);
            nb.cy = CY_W'(py - vol_ry);
            nb.cz = CZ_W'(pz - vol_rz);
            nb.norm = NORM_W'(root);
            norm_q.push_back(nb);
        end

        at_x = px + 1;
        if (at_x >= vol_w)
        begin
            at_x = 0;
            at_y = py + 1;
            if (at_y >= vol_h)
            begin
                at_y = 0;
                at_z = pz + 1;
                if (at_z >= vol_p) at_z = 0;
            end
        end
    endtask

    // Hold cfg_valid across back-to-back writes; the caller lowers it.
    task automatic cfg_write(input int unsigned idx, input int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_write(idx, val);
    endtask

    task automatic wait_idle();
        wait (sample_q.size() == 0 && !s_tvalid && norm_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write all six registers; unused upper data bits carry random noise.
    task automatic setup_volume(input int unsigned w, h, p, rx, ry, rz);
        wait_idle();
        cfg_write(REG_WIDTH,    ($urandom_range(0, 15) << 8) | w[7:0]);
        cfg_write(REG_HEIGHT,   ($urandom_range(0, 15) << 8) | h[7:0]);
        cfg_write(REG_PLANES,   p & 32'hFFF);
        cfg_write(REG_RADIUS_X, ($urandom_range(0, 255) << 4) | rx[3:0]);
        cfg_write(REG_RADIUS_Y, ($urandom_range(0, 255) << 4) | ry[3:0]);
        cfg_write(REG_RADIUS_Z, ($urandom_range(0, 511) << 3) | rz[2:0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return SAMPLE_W'($urandom_range(0, 3) - 1);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Queue n voxels; mode 0 random, 1 extremes cycled, 2 most negative only.
    task automatic send_voxels(input int n, input int mode);
        logic [SAMPLE_W-1:0] smp;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                1: case (i % 5)
                       0: smp = 16'h8000;
                       1: smp = 16'h7FFF;
                       2: smp = 16'h0000;
                       3: smp = 16'hFFFF;
                       default: smp = 16'h0001;
                   endcase
                2: smp = 16'h8000;
                default: smp = pick_sample();
            endcase
            predict_norm(smp);
            sample_q.push_back(smp);
        end
        planned += n;
    endtask

    initial
    begin
        int unsigned w, h, p, rx, ry, rz;
        reg_w = 128; reg_h = 128; reg_p = 64; reg_rx = 2; reg_ry = 2; reg_rz = 1;
        at_x = 0; at_y = 0; at_z = 0;
        row_total = 0;
        foreach (sq_hist[i]) sq_hist[i] = 0;
        foreach (col_total[i]) col_total[i] = 0;
        foreach (box_total[i]) box_total[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: small cube with extremes, then the clamping corners.
        setup_volume(3, 3, 3, 1, 1, 1);
        send_voxels(27, 1);
        setup_volume(0, 0, 0, 0, 0, 0);              // zero sizes act as one voxel
        send_voxels(10, 1);
        setup_volume(255, 2, 1, 15, 0, 0);           // oversize width and radius
        send_voxels(256, 0);
        setup_volume(17, 17, 1, 8, 8, 0);            // widest window, worst-case samples
        send_voxels(289, 2);
        setup_volume(1, 1, 9, 0, 0, 7);              // deepest window via clamped radius
        send_voxels(9, 2);
        setup_volume(4, 4, 2, 2, 2, 0);              // window larger than the volume
        send_voxels(32, 0);
        setup_volume(2, 128, 1, 0, 8, 0);            // tallest plane
        send_voxels(256, 0);
        // Out-of-range indexes must be dropped; planes 4095 gets overwritten.
        wait_idle();
        cfg_write(6, $urandom);
        cfg_write(7, $urandom);
        cfg_write(REG_PLANES, MAX_PLANES);
        @(negedge clk);
        cfg_valid <= 1'b0;

        // Random volumes, mostly with a window that fits.
        while (planned < ITEM_TARGET)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            p = $urandom_range(1, 5);
            if ($urandom_range(0, 7) == 0)
            begin
                rx = $urandom_range(0, 15);
                ry = $urandom_range(0, 15);
                rz = $urandom_range(0, 7);
            end
            else
            begin
                rx = $urandom_range(0, (w - 1) / 2);
                ry = $urandom_range(0, (h - 1) / 2);
                rz = $urandom_range(0, (p - 1) / 2);
            end
            setup_volume(w, h, p, rx, ry, rz);
            send_voxels(w * h * p * $urandom_range(1, 2), 0);
        end

        wait_idle();
        if (errors == 0)
            $display("** local_window_l2_norm_3d: PASSED **");
        else
            $display("** local_window_l2_norm_3d: FAILED **");
        $finish;
    end

    // Driver: replace the offered sample only once it has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (sample_q.size() > 0 &&
                !(in_beats < 600 && $urandom_range(0, 99) < 33) &&
                !(in_beats >= 600 && in_beats < 1200 && $urandom_range(0, 99) < 84))
            begin
                s_tdata  <= sample_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold to fill the block.
    always @(negedge clk)
    begin
        if (!hold_done && in_beats >= HOLD_START)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES)
                hold_done <= 1'b1;
            m_tready <= 1'b0;
        end
        else if (in_beats < 600)
            m_tready <= ($urandom_range(0, 99) >= 84);
        else if (in_beats < 1200)
            m_tready <= ($urandom_range(0, 99) >= 33);
        else
            m_tready <= 1'b1;
    end

    // Monitor: count input beats and compare each output beat.
    always @(posedge clk)
    begin
        norm_beat_t got;
        norm_beat_t want;
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            in_beats <= in_beats + 1;
        if (m_tvalid && m_tready)
        begin
            got.cx   = m_tdata[6:0];
            got.cy   = m_tdata[13:7];
            got.cz   = m_tdata[25:14];
            got.norm = m_tdata[46:26];
            if (norm_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: x=%0d y=%0d z=%0d norm=%0d",
                             got.cx, got.cy, got.cz, got.norm);
            end
            else
            begin
                want = norm_q.pop_front();
                if (got.cx !== want.cx || got.cy !== want.cy ||
                    got.cz !== want.cz || got.norm !== want.norm)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d,%0d,%0d norm=%0d got %0d,%0d,%0d norm=%0d",
                                 want.cx, want.cy, want.cz, want.norm,
                                 got.cx, got.cy, got.cz, got.norm);
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves anywhere for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cnt <= 0;
        else if (idle_cnt >= STALL_LIMIT)
        begin
            $display("** local_window_l2_norm_3d: FAILED **");
            $finish;
        end
        else
            idle_cnt <= idle_cnt + 1;
    end

endmodule

FILE: sim.f
hw/rtl/lwn_pkg.sv
hw/rtl/local_window_l2_norm_3d.sv
tb/tb_local_window_l2_norm_3d.sv
